// ===== rtl/core/ctbe_pkg.sv =====
package ctbe_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned LenW     = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    FUNC_LEFT  = 3'd0,
    FUNC_RIGHT = 3'd1,
    FUNC_INS   = 3'd2,
    FUNC_CUT   = 3'd3,
    FUNC_COPY  = 3'd4,
    FUNC_PASTE = 3'd5,
    FUNC_READ  = 3'd6,
    FUNC_NOP   = 3'd7
  } func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  ch;
    logic [10:0] count;
    logic [9:0]  index;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [10:0] text_length;
    logic [10:0] cursor_place;
    logic [10:0] clip_length;
    logic [7:0]  read_char;
  } out_item_t;

endpackage

// ===== rtl/core/ctbe_ram.sv =====
module ctbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/cursor_text_buffer_editor.sv =====
// Gap-free text buffer editor with a cursor and a clipboard. Each command
// yields one result. Moves, reads, rejected commands and zero-count cut or
// copy move no characters. Insert shifts the T characters after the cursor
// up; copy moves the N characters taken into the clipboard; cut does the
// same and then shifts the other T - N characters of the tail down; paste
// shifts the tail up and then writes the C clipboard characters at the
// cursor. Each character moved goes through a read state and then a write
// state of the memories. One command is in work at a time; the result
// register lets the next command be accepted while the previous result
// waits.
module cursor_text_buffer_editor
  import ctbe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD,
    ST_WR,
    ST_DONE,
    ST_READ
  } state_e;

  // Phases of a copy loop.
  typedef enum logic [1:0] {
    PH_SHIFT,
    PH_CLIP,
    PH_PUT
  } phase_e;

  state_e      state_q;
  phase_e      phase_q;
  in_item_t    cmd_q;
  logic [LenW-1:0] text_cnt_q, cur_q, clip_cnt_q;
  logic [LenW-1:0] n_q, left_q, src_q, dst_q;
  logic        dir_up_q;   // shift toward higher addresses (walk down)
  logic        status_q;
  logic [7:0]  rd_char_q;
  logic        read_hit_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic            t_we, c_we;
  logic [AddrW-1:0] t_waddr, t_raddr, c_waddr, c_raddr;
  logic [7:0]      t_wdata, c_wdata, t_rdata, c_rdata;

  ctbe_ram #(.Width(8), .Depth(Capacity)) u_text (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  ctbe_ram #(.Width(8), .Depth(Capacity)) u_clip (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  logic [LenW-1:0] tail, take_n;
  logic [LenW:0]   paste_sum;

  assign tail      = text_cnt_q - cur_q;
  assign take_n    = (cmd_q.count < tail) ? cmd_q.count : tail;
  assign paste_sum = {1'b0, text_cnt_q} + {1'b0, clip_cnt_q};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Memory ports are driven from the loop registers, except for the read of a read command and the insert write.
  always_comb begin
    t_we    = 1'b0;
    c_we    = 1'b0;
    t_waddr = dst_q[AddrW-1:0];
    t_wdata = t_rdata;
    c_waddr = dst_q[AddrW-1:0];
    c_wdata = t_rdata;
    t_raddr = src_q[AddrW-1:0];
    c_raddr = src_q[AddrW-1:0];
    if (state_q == ST_READ) begin
      t_raddr = cmd_q.index;
    end
    if (state_q == ST_WR) begin
      case (phase_q)
        PH_SHIFT: t_we = 1'b1;
        PH_CLIP:  c_we = 1'b1;
        PH_PUT: begin
          t_we    = 1'b1;
          t_wdata = c_rdata;
        end
        default: ;
      endcase
    end
    if (state_q == ST_DONE && func_e'(cmd_q.func) == FUNC_INS && !status_q) begin
      t_we    = 1'b1;
      t_waddr = cur_q[AddrW-1:0];
      t_wdata = cmd_q.ch;
    end
  end

  // Command sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_SHIFT;
      cmd_q       <= '0;
      text_cnt_q  <= '0;
      cur_q       <= '0;
      clip_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      status_q    <= 1'b0;
      rd_char_q   <= '0;
      dir_up_q    <= 1'b0;
      n_q         <= '0;
      left_q      <= '0;
      src_q       <= '0;
      dst_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q     <= in_data_i;
            status_q  <= 1'b0;
            rd_char_q <= '0;
            state_q   <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state_q <= ST_DONE;
          case (func_e'(cmd_q.func))
            FUNC_LEFT:  if (cur_q != '0) cur_q <= cur_q - 1'b1;
            FUNC_RIGHT: if (cur_q < text_cnt_q) cur_q <= cur_q + 1'b1;
            FUNC_INS: begin
              if (text_cnt_q >= LenW'(Capacity)) begin
                status_q <= 1'b1;
              end else if (tail != '0) begin
                phase_q  <= PH_SHIFT;
                dir_up_q <= 1'b1;
                left_q   <= tail;
                src_q    <= text_cnt_q - 1'b1;
                dst_q    <= text_cnt_q;
                state_q  <= ST_RD;
              end
            end
            FUNC_CUT, FUNC_COPY: begin
              n_q <= take_n;
              if (take_n != '0) begin
                phase_q <= PH_CLIP;
                left_q  <= take_n;
                src_q   <= cur_q;
                dst_q   <= '0;
                state_q <= ST_RD;
              end
            end
            FUNC_PASTE: begin
              if (paste_sum > (LenW+1)'(Capacity)) begin
                status_q <= 1'b1;
              end else if (clip_cnt_q != '0) begin
                dir_up_q <= 1'b1;
                if (tail != '0) begin
                  phase_q <= PH_SHIFT;
                  left_q  <= tail;
                  src_q   <= text_cnt_q - 1'b1;
                  dst_q   <= paste_sum[LenW-1:0] - 1'b1;
                end else begin
                  phase_q <= PH_PUT;
                  left_q  <= clip_cnt_q;
                  src_q   <= '0;
                  dst_q   <= cur_q;
                end
                state_q <= ST_RD;
              end
            end
            FUNC_READ: state_q <= ST_READ;
            default: ;
          endcase
        end
        ST_RD: state_q <= ST_WR;
        ST_WR: begin
          // Step the addresses after each moved character.
          if (left_q != LenW'(1)) begin
            left_q <= left_q - 1'b1;
            if (phase_q == PH_SHIFT && dir_up_q) begin
              src_q <= src_q - 1'b1;
              dst_q <= dst_q - 1'b1;
            end else begin
              src_q <= src_q + 1'b1;
              dst_q <= dst_q + 1'b1;
            end
            state_q <= ST_RD;
          end else if (phase_q == PH_CLIP) begin
            clip_cnt_q <= n_q;
            if (func_e'(cmd_q.func) == FUNC_CUT && tail != n_q) begin
              phase_q  <= PH_SHIFT;
              dir_up_q <= 1'b0;
              left_q   <= tail - n_q;
              src_q    <= cur_q + n_q;
              dst_q    <= cur_q;
              state_q  <= ST_RD;
            end else begin
              state_q <= ST_DONE;
            end
          end else if (phase_q == PH_SHIFT && dir_up_q &&
                       func_e'(cmd_q.func) == FUNC_PASTE) begin
            phase_q <= PH_PUT;
            left_q  <= clip_cnt_q;
            src_q   <= '0;
            dst_q   <= cur_q;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_READ: state_q <= ST_DONE;
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            // Commit counters and publish the result.
            case (func_e'(cmd_q.func))
              FUNC_INS: if (!status_q) begin
                text_cnt_q <= text_cnt_q + 1'b1;
                cur_q      <= cur_q + 1'b1;
              end
              FUNC_CUT: begin
                text_cnt_q <= text_cnt_q - n_q;
                clip_cnt_q <= n_q;
              end
              FUNC_COPY: clip_cnt_q <= n_q;
              FUNC_PASTE: if (!status_q) begin
                text_cnt_q <= paste_sum[LenW-1:0];
                cur_q      <= cur_q + clip_cnt_q;
              end
              default: ;
            endcase
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // The read character is valid only in the first cycle after ST_READ,
      // so it is held here in case the result has to wait.
      if (read_hit_q) begin
        rd_char_q <= t_rdata;
      end
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_q.status       <= status_q;
        out_q.read_char    <= read_hit_q ? t_rdata : rd_char_q;
        out_q.clip_length  <= (func_e'(cmd_q.func) == FUNC_CUT ||
                               func_e'(cmd_q.func) == FUNC_COPY) ? n_q : clip_cnt_q;
        case (func_e'(cmd_q.func))
          FUNC_INS: begin
            out_q.text_length  <= status_q ? text_cnt_q : text_cnt_q + 1'b1;
            out_q.cursor_place <= status_q ? cur_q : cur_q + 1'b1;
          end
          FUNC_CUT: begin
            out_q.text_length  <= text_cnt_q - n_q;
            out_q.cursor_place <= cur_q;
          end
          FUNC_PASTE: begin
            out_q.text_length  <= status_q ? text_cnt_q : paste_sum[LenW-1:0];
            out_q.cursor_place <= status_q ? cur_q : cur_q + clip_cnt_q;
          end
          default: begin
            out_q.text_length  <= text_cnt_q;
            out_q.cursor_place <= cur_q;
          end
        endcase
      end
    end
  end

  // Marks the cycle in which read data is valid and inside the text.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_hit_q <= 1'b0;
    end else begin
      read_hit_q <= (state_q == ST_READ) &&
                    ({1'b0, cmd_q.index} < text_cnt_q);
    end
  end

  // Assertions.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_q <= text_cnt_q)
    else $error("cursor beyond text");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_cnt_q <= LenW'(Capacity)) else $error("text overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t_we && c_we) == 1'b0) else $error("both stores written");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DECIDE) else $error("bad accept");

endmodule
